// File: design/gip_host_frame_responder_unit_defines.svh
// assertion helpers for the frame responder
`ifndef GIP_HOST_FRAME_RESPONDER_UNIT_DEFINES_SVH
`define GIP_HOST_FRAME_RESPONDER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GIP_HFR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define GIP_HFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/gip_hfr_pkg.sv
package gip_hfr_pkg;

   localparam int MAX_FRAME_BYTES_DEFAULT = 256;

   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int VALUE_W = 28;

   // option byte bits
   localparam int OPT_CHUNKED = 7;
   localparam int OPT_START   = 6;
   localparam int OPT_ACK     = 4;

   localparam logic [7:0] CMD_ANNOUNCE = 8'h02;
   localparam logic [7:0] CMD_IDENTIFY = 8'h04;

   localparam logic [3:0] PHASE_CHUNK = 4'd4;
   localparam logic [3:0] PHASE_DONE  = 4'd8;

   localparam logic [2:0] KIND_ACK       = 3'd0;
   localparam logic [2:0] KIND_IDENT_REQ = 3'd1;
   localparam logic [2:0] KIND_POWER_ON  = 3'd2;
   localparam logic [2:0] KIND_WAKE      = 3'd3;
   localparam logic [2:0] KIND_AUTH      = 3'd4;

   // pending response bits in the back end, emitted lowest first
   localparam int PEND_ACK   = 0;
   localparam int PEND_IDENT = 1;
   localparam int PEND_POWER = 2;
   localparam int PEND_WAKE0 = 3;
   localparam int PEND_AUTH  = 4;
   localparam int PEND_WAKE1 = 5;
   localparam int PEND_W     = 6;

   typedef struct packed {
      logic        ack;
      logic        id_req;
      logic        power_up;
      logic [7:0]  seq;
      logic [7:0]  cmd;
      logic [15:0] got;
      logic [15:0] rem;
   } record_type;

endpackage

// File: design/gip_host_frame_responder_unit.sv
// one received byte per cycle while req_tready is high; the parser keeps up with back-to-back bytes
// a frame's first response passes the snapshot and clip stages, the queue and the pending bits to the output register
// responses leave one per cycle from the output register while rsp_tready is high; a frame yields up to 5
// input stalls while the 4-entry response queue, counting frames still in the end stages, is full
// synchronous active-high reset clears parse, reassembly, queue and output state
`include "gip_host_frame_responder_unit_defines.svh"

module gip_host_frame_responder_unit
   import gip_hfr_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // out_seq[7:0], acked_cmd[15:8],
                                    // bytes_received[31:16], bytes_remaining[47:32]
   output logic [2:0]  rsp_tuser,   // frame_kind[2:0]
   output logic        rsp_tlast
);

   logic                     q_push;
   record_type               q_push_record;
   logic                     q_pop;
   logic                     q_empty;
   record_type               q_head;
   logic [QUEUE_COUNT_W-1:0] q_count;

   gip_hfr_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .queue_count (q_count),
      .push        (q_push),
      .push_record (q_push_record)
   );

   gip_hfr_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (q_push),
      .push_record (q_push_record),
      .pop         (q_pop),
      .empty       (q_empty),
      .head        (q_head),
      .count       (q_count)
   );

   gip_hfr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (q_empty),
      .queue_head  (q_head),
      .pop         (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   `GIP_HFR_ASSERT_IMP(a_queue_no_overflow, q_push, (q_count < QUEUE_COUNT_W'(QUEUE_DEPTH)) || q_pop, "response queue overflow")
   `GIP_HFR_ASSERT_IMP(a_own_seq_nonzero, rsp_tvalid && (rsp_tuser != KIND_ACK), rsp_tdata[7:0] != 8'd0, "own sequence is zero")
   `GIP_HFR_ASSERT_IMP(a_plain_payload_zero, rsp_tvalid && (rsp_tuser != KIND_ACK), rsp_tdata[47:8] == 40'd0, "non-ack response carries payload")
   `GIP_HFR_ASSERT_NEXT(a_pop_not_empty, q_empty, !q_pop || !q_empty, "pop from empty queue")

endmodule

// File: design/gip_hfr_front.sv
module gip_hfr_front
   import gip_hfr_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,
   input  logic                     req_tlast,
   input  logic [QUEUE_COUNT_W-1:0] queue_count,
   output logic                     push,
   output record_type               push_record
);

   localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
   localparam logic [PW-1:0] MAX_POS = PW'(MAX_FRAME_BYTES);
   localparam logic [PW-1:0] MIN_POS = PW'(4);
   localparam logic [PW-1:0] HDR_RESET = PW'(3);

   // per-frame parse
   logic [PW-1:0]      pos_ff, pos_in;
   logic [7:0]         cmd_ff, cmd_in;
   logic [7:0]         opts_ff, opts_in;
   logic [7:0]         seq_ff, seq_in;
   logic [3:0]         phase_ff, phase_in;
   logic [VALUE_W-1:0] len_ff, len_in;
   logic [VALUE_W-1:0] chunk_ff, chunk_in;
   logic [PW-1:0]      hdr_ff, hdr_in;

   // values after taking the current byte
   logic [PW-1:0]      t_pos, t_hdr;
   logic [7:0]         t_cmd, t_opts, t_seq;
   logic [3:0]         t_phase;
   logic [VALUE_W-1:0] t_len, t_chunk;

   // end-of-frame snapshot
   logic               s1_valid_ff, s1_valid_in;
   logic [7:0]         s1_cmd_ff, s1_opts_ff, s1_seq_ff;
   logic [VALUE_W-1:0] s1_len_ff, s1_chunk_ff;
   logic [PW-1:0]      s1_hdr_ff, s1_n_ff;

   // clipped length stage
   logic               s2_valid_ff;
   logic [7:0]         s2_cmd_ff, s2_opts_ff, s2_seq_ff;
   logic [VALUE_W-1:0] s2_chunk_ff, s2_plen_ff;
   logic [PW-1:0]      avail;
   logic [VALUE_W-1:0] plen_in;

   // reassembly state
   logic [VALUE_W-1:0] total_ff, total_in;
   logic [VALUE_W-1:0] got_ff, got_in;
   logic [7:0]         rcmd_ff, rcmd_in;
   logic               ident_ff, ident_in;

   logic               accept;
   logic [1:0]         idx;
   logic [4:0]         shamt;
   logic [VALUE_W-1:0] part;
   logic               stop;
   logic [QUEUE_COUNT_W:0] occupancy;

   logic               chunked;
   logic [VALUE_W-1:0] total_new, got_base, coff;
   logic [7:0]         rcmd_new;
   logic [VALUE_W:0]   sum;
   logic               in_bounds;
   logic               power_up;

   // a record may still be in the snapshot or clip stage, so reserve its slot
   assign occupancy = {1'b0, queue_count} + (QUEUE_COUNT_W + 1)'(s1_valid_ff)
                      + (QUEUE_COUNT_W + 1)'(s2_valid_ff);
   assign req_tready = occupancy < (QUEUE_COUNT_W + 1)'(QUEUE_DEPTH);
   assign accept = req_tvalid && req_tready;

   assign idx   = phase_ff[1:0];
   assign shamt = 5'(idx) * 5'd7;
   assign part  = {{(VALUE_W - 7){1'b0}}, req_tdata[6:0]} << shamt;
   assign stop  = !req_tdata[7] || (idx == 2'd3);

   always_comb begin
      t_pos   = pos_ff;
      t_hdr   = hdr_ff;
      t_cmd   = cmd_ff;
      t_opts  = opts_ff;
      t_seq   = seq_ff;
      t_phase = phase_ff;
      t_len   = len_ff;
      t_chunk = chunk_ff;
      if (pos_ff < MAX_POS) begin
         t_pos = pos_ff + PW'(1);
         if (pos_ff == PW'(0)) begin
            t_cmd = req_tdata;
         end else if (pos_ff == PW'(1)) begin
            t_opts = req_tdata;
         end else if (pos_ff == PW'(2)) begin
            t_seq = req_tdata;
         end else if (phase_ff < PHASE_DONE) begin
            t_hdr = pos_ff + PW'(1);
            if (phase_ff < PHASE_CHUNK) begin
               t_len = len_ff | part;
               if (stop) begin
                  t_phase = opts_ff[OPT_CHUNKED] ? PHASE_CHUNK : PHASE_DONE;
               end else begin
                  t_phase = phase_ff + 4'd1;
               end
            end else begin
               t_chunk = chunk_ff | part;
               t_phase = stop ? PHASE_DONE : phase_ff + 4'd1;
            end
         end
      end
   end

   always_comb begin
      pos_in      = pos_ff;
      hdr_in      = hdr_ff;
      cmd_in      = cmd_ff;
      opts_in     = opts_ff;
      seq_in      = seq_ff;
      phase_in    = phase_ff;
      len_in      = len_ff;
      chunk_in    = chunk_ff;
      s1_valid_in = 1'b0;
      if (accept) begin
         if (req_tlast) begin
            pos_in      = '0;
            hdr_in      = HDR_RESET;
            cmd_in      = '0;
            opts_in     = '0;
            seq_in      = '0;
            phase_in    = '0;
            len_in      = '0;
            chunk_in    = '0;
            s1_valid_in = t_pos >= MIN_POS;
         end else begin
            pos_in   = t_pos;
            hdr_in   = t_hdr;
            cmd_in   = t_cmd;
            opts_in  = t_opts;
            seq_in   = t_seq;
            phase_in = t_phase;
            len_in   = t_len;
            chunk_in = t_chunk;
         end
      end
   end

   // header never runs past the byte count, so the room left is n - header
   assign avail   = s1_n_ff - s1_hdr_ff;
   assign plen_in = (s1_len_ff > VALUE_W'(avail)) ? VALUE_W'(avail) : s1_len_ff;

   // reassembly decision on the clipped frame
   assign chunked   = s2_opts_ff[OPT_CHUNKED];
   assign total_new = s2_opts_ff[OPT_START] ? s2_chunk_ff : total_ff;
   assign got_base  = s2_opts_ff[OPT_START] ? '0 : got_ff;
   assign rcmd_new  = s2_opts_ff[OPT_START] ? s2_cmd_ff : rcmd_ff;
   assign coff      = s2_opts_ff[OPT_START] ? '0 : s2_chunk_ff;
   assign sum       = {1'b0, coff} + {1'b0, s2_plen_ff};
   assign in_bounds = (rcmd_new == s2_cmd_ff) && (sum <= {1'b0, total_new});

   assign power_up = chunked && (s2_cmd_ff == CMD_IDENTIFY) && !ident_ff
                     && ((in_bounds && (sum == {1'b0, total_new}))
                         || (got_base >= total_new));

   always_comb begin
      total_in = total_ff;
      got_in   = got_ff;
      rcmd_in  = rcmd_ff;
      ident_in = ident_ff;
      if (s2_valid_ff && chunked) begin
         total_in = total_new;
         rcmd_in  = rcmd_new;
         got_in   = (in_bounds && (sum > {1'b0, got_base})) ? sum[VALUE_W-1:0] : got_base;
         if (power_up) begin
            ident_in = 1'b1;
         end
      end
   end

   always_comb begin
      push_record.ack      = s2_opts_ff[OPT_ACK];
      push_record.id_req   = s2_cmd_ff == CMD_ANNOUNCE;
      push_record.power_up = power_up;
      push_record.seq      = s2_seq_ff;
      push_record.cmd      = s2_cmd_ff;
      push_record.got      = chunked ? sum[15:0] : s2_plen_ff[15:0];
      push_record.rem      = chunked ? (total_new[15:0] - sum[15:0]) : 16'd0;
   end

   assign push = s2_valid_ff
                 && (push_record.ack || push_record.id_req || push_record.power_up);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         hdr_ff      <= HDR_RESET;
         cmd_ff      <= '0;
         opts_ff     <= '0;
         seq_ff      <= '0;
         phase_ff    <= '0;
         len_ff      <= '0;
         chunk_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         total_ff    <= '0;
         got_ff      <= '0;
         rcmd_ff     <= '0;
         ident_ff    <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         hdr_ff      <= hdr_in;
         cmd_ff      <= cmd_in;
         opts_ff     <= opts_in;
         seq_ff      <= seq_in;
         phase_ff    <= phase_in;
         len_ff      <= len_in;
         chunk_ff    <= chunk_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         total_ff    <= total_in;
         got_ff      <= got_in;
         rcmd_ff     <= rcmd_in;
         ident_ff    <= ident_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_cmd_ff   <= t_cmd;
         s1_opts_ff  <= t_opts;
         s1_seq_ff   <= t_seq;
         s1_len_ff   <= t_len;
         s1_chunk_ff <= t_chunk;
         s1_hdr_ff   <= t_hdr;
         s1_n_ff     <= t_pos;
      end
      if (s1_valid_ff) begin
         s2_cmd_ff   <= s1_cmd_ff;
         s2_opts_ff  <= s1_opts_ff;
         s2_seq_ff   <= s1_seq_ff;
         s2_chunk_ff <= s1_chunk_ff;
         s2_plen_ff  <= plen_in;
      end
   end

endmodule

// File: design/gip_hfr_queue.sv
module gip_hfr_queue
   import gip_hfr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  record_type               push_record,
   input  logic                     pop,
   output logic                     empty,
   output record_type               head,
   output logic [QUEUE_COUNT_W-1:0] count
);

   localparam logic [QUEUE_PTR_W-1:0] LAST_SLOT = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

   record_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_W-1:0]   count_ff, count_in;

   assign empty = count_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];
   assign count = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_record;
      end
   end

endmodule

// File: design/gip_hfr_back.sv
module gip_hfr_back
   import gip_hfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        queue_empty,
   input  record_type  queue_head,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   logic [PEND_W-1:0] pend_ff, pend_in;
   record_type        work_ff;
   logic [7:0]        tx_seq_ff, tx_seq_in, tx_seq_inc;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [47:0]       rsp_data_ff, rsp_data_in;
   logic [2:0]        rsp_kind_ff, rsp_kind_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              emit;
   logic [PEND_W-1:0] pend_rest;

   assign emit      = (pend_ff != '0) && (!rsp_valid_ff || rsp_tready);
   assign pend_rest = pend_ff & (pend_ff - PEND_W'(1));
   assign pop       = !queue_empty && ((pend_ff == '0) || (emit && (pend_rest == '0)));

   // own sequence wraps past zero
   assign tx_seq_inc = (tx_seq_ff == 8'hFF) ? 8'd1 : tx_seq_ff + 8'd1;

   always_comb begin
      rsp_kind_in = KIND_WAKE;
      if (pend_ff[PEND_ACK]) begin
         rsp_kind_in = KIND_ACK;
      end else if (pend_ff[PEND_IDENT]) begin
         rsp_kind_in = KIND_IDENT_REQ;
      end else if (pend_ff[PEND_POWER]) begin
         rsp_kind_in = KIND_POWER_ON;
      end else if (pend_ff[PEND_WAKE0]) begin
         rsp_kind_in = KIND_WAKE;
      end else if (pend_ff[PEND_AUTH]) begin
         rsp_kind_in = KIND_AUTH;
      end
   end

   always_comb begin
      if (pend_ff[PEND_ACK]) begin
         rsp_data_in = {work_ff.rem, work_ff.got, work_ff.cmd, work_ff.seq};
      end else begin
         rsp_data_in = {40'd0, tx_seq_ff};
      end
      rsp_last_in = pend_rest == '0;
   end

   always_comb begin
      pend_in      = pend_ff;
      tx_seq_in    = tx_seq_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         pend_in      = pend_rest;
         rsp_valid_in = 1'b1;
         if (!pend_ff[PEND_ACK]) begin
            tx_seq_in = tx_seq_inc;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (pop) begin
         pend_in = '0;
         pend_in[PEND_ACK]   = queue_head.ack;
         pend_in[PEND_IDENT] = queue_head.id_req;
         pend_in[PEND_POWER] = queue_head.power_up;
         pend_in[PEND_WAKE0] = queue_head.power_up;
         pend_in[PEND_AUTH]  = queue_head.power_up;
         pend_in[PEND_WAKE1] = queue_head.power_up;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         tx_seq_ff    <= 8'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         tx_seq_ff    <= tx_seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         work_ff <= queue_head;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= rsp_kind_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
